[rtl/pet_pkg.sv]
package pet_pkg;

    // Default number of table slots
    localparam int TABLE_DEPTH = 16;

    // Field widths
    localparam int OP_W     = 2;
    localparam int TID_W    = 8;
    localparam int PID_W    = 13;
    localparam int PROG_W   = 16;
    localparam int NSEC_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Packed beat widths, rounded up to whole bytes
    localparam int IN_W  = 48;
    localparam int OUT_W = 56;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PAT    = 2'd0;
    localparam logic [OP_W-1:0] OP_PMT    = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NIT         = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WRONG_TABLE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;

    // NIT handling
    localparam logic [PID_W-1:0]  NIT_PID        = 13'h0010;
    localparam logic [NSEC_W-1:0] NIT_KEEP_BELOW = 8'd8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic scan_clear;
        logic scan_step;
        logic commit;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic out_busy;
    } t_dp_sts;

endpackage

[rtl/pet_ram.sv]
module pet_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pet_ctrl.sv]
module pet_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  pet_pkg::t_dp_sts i_sts,
    output pet_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_COMMIT = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // Next state and commands for the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.scan_clear = 1'b1;
                n_state          = i_sts.needs_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The read of the last slot is compared in this cycle.
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/pet_dp.sv]
module pet_dp #(
    parameter int TABLE_DEPTH = pet_pkg::TABLE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pet_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [pet_pkg::OUT_W-1:0] o_m_tdata,
    input  pet_pkg::t_dp_cmd          i_cmd,
    output pet_pkg::t_dp_sts          o_sts
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_W = pet_pkg::PID_W + pet_pkg::PROG_W;

    // Captured input item
    logic [pet_pkg::OP_W-1:0]   r_op;
    logic [pet_pkg::TID_W-1:0]  r_tid;
    logic [pet_pkg::PID_W-1:0]  r_key;
    logic [pet_pkg::PROG_W-1:0] r_prog;
    logic [pet_pkg::NSEC_W-1:0] r_nsec;

    // Per-slot flags and running counts
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] n_valid;
    logic [TABLE_DEPTH-1:0] r_pend;
    logic [TABLE_DEPTH-1:0] n_pend;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          n_cnt;
    logic [CW-1:0]          r_pcnt;
    logic [CW-1:0]          n_pcnt;

    // Default program
    logic                       r_best_v;
    logic                       n_best_v;
    logic [pet_pkg::PROG_W-1:0] r_best_prog;
    logic [pet_pkg::PROG_W-1:0] n_best_prog;
    logic [pet_pkg::PID_W-1:0]  r_best_pid;
    logic [pet_pkg::PID_W-1:0]  n_best_pid;

    // Scan state
    logic [AW-1:0]              r_scan_addr;
    logic [AW-1:0]              r_rd_addr;
    logic                       r_rd_vld;
    logic                       r_hit;
    logic [AW-1:0]              r_hit_slot;
    logic [pet_pkg::PROG_W-1:0] r_hit_prog;
    logic                       r_free;
    logic [AW-1:0]              r_free_slot;

    // Result and output register
    logic [pet_pkg::STATUS_W-1:0] r_res_status;
    logic [pet_pkg::STATUS_W-1:0] n_res_status;
    logic [pet_pkg::PROG_W-1:0]   r_res_found;
    logic [pet_pkg::PROG_W-1:0]   n_res_found;
    logic                         r_out_valid;
    logic [pet_pkg::OUT_W-1:0]    r_out_data;

    logic                       w_nit;
    logic [AW-1:0]              w_slot;
    logic                       w_ram_we;
    logic [RAM_W-1:0]           w_rdata;
    logic [pet_pkg::PID_W-1:0]  w_rd_pid;
    logic [pet_pkg::PROG_W-1:0] w_rd_prog;

    // Slot memory: PID in the upper bits, program number in the lower.
    pet_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_slot),
        .i_wdata ({r_key, r_prog}),
        .i_raddr (r_scan_addr),
        .o_rdata (w_rdata)
    );

    assign w_rd_pid  = w_rdata[RAM_W-1:pet_pkg::PROG_W];
    assign w_rd_prog = w_rdata[pet_pkg::PROG_W-1:0];

    assign w_nit  = (r_key == pet_pkg::NIT_PID) && (r_nsec >= pet_pkg::NIT_KEEP_BELOW);
    assign w_slot = r_hit ? r_hit_slot : r_free_slot;

    // Status towards the controller.
    always_comb begin
        o_sts.needs_scan = (r_op == pet_pkg::OP_PMT) || (r_op == pet_pkg::OP_LOOKUP) ||
                           ((r_op == pet_pkg::OP_PAT) && (r_tid == '0) && !w_nit);
        o_sts.scan_last  = (r_scan_addr == AW'(TABLE_DEPTH - 1));
        o_sts.out_busy   = r_out_valid && !i_m_tready;
    end

    // Capture of the input beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_s_tdata[1:0];
            r_tid  <= i_s_tdata[9:2];
            r_key  <= i_s_tdata[22:10];
            r_prog <= i_s_tdata[38:23];
            r_nsec <= i_s_tdata[46:39];
        end
    end

    // Scan through the slots: the compare follows in the cycle after the address goes out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_clear) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_rd_vld) begin
                if (r_valid[r_rd_addr] && (w_rd_pid == r_key) && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!r_valid[r_rd_addr] && !r_free) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_scan_addr;
        if (i_cmd.scan_clear) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + AW'(1);
        end
        if (r_rd_vld && !i_cmd.scan_clear) begin
            if (r_valid[r_rd_addr] && (w_rd_pid == r_key) && !r_hit) begin
                r_hit_slot <= r_rd_addr;
                r_hit_prog <= w_rd_prog;
            end
            if (!r_valid[r_rd_addr] && !r_free) begin
                r_free_slot <= r_rd_addr;
            end
        end
    end

    // Update of the table and the result at commit, after the scan if the item needs one.
    always_comb begin
        n_valid      = r_valid;
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        n_pcnt       = r_pcnt;
        n_best_v     = r_best_v;
        n_best_prog  = r_best_prog;
        n_best_pid   = r_best_pid;
        n_res_status = pet_pkg::ST_NOT_FOUND;
        n_res_found  = '0;
        w_ram_we     = 1'b0;
        case (r_op)
            pet_pkg::OP_PAT: begin
                if (r_tid != '0) begin
                    n_res_status = pet_pkg::ST_WRONG_TABLE;
                end else if (w_nit) begin
                    n_res_status = pet_pkg::ST_NIT;
                end else if (!r_hit && !r_free) begin
                    n_res_status = pet_pkg::ST_FULL;
                end else begin
                    n_res_status   = pet_pkg::ST_STORED;
                    w_ram_we       = i_cmd.commit;
                    n_valid[w_slot] = 1'b1;
                    n_pend[w_slot]  = 1'b1;
                    if (!r_hit) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                    if (!(r_hit && r_pend[w_slot])) begin
                        n_pcnt = r_pcnt + CW'(1);
                    end
                    // A tie keeps the earlier default.
                    if (!r_best_v || (r_prog < r_best_prog)) begin
                        n_best_v    = 1'b1;
                        n_best_prog = r_prog;
                        n_best_pid  = r_key;
                    end
                end
            end
            pet_pkg::OP_PMT: begin
                if (r_hit) begin
                    n_res_status    = pet_pkg::ST_FOUND;
                    n_pend[w_slot]  = 1'b0;
                    if (r_pend[w_slot]) begin
                        n_pcnt = r_pcnt - CW'(1);
                    end
                end
            end
            pet_pkg::OP_LOOKUP: begin
                if (r_hit) begin
                    n_res_status = pet_pkg::ST_FOUND;
                    n_res_found  = r_hit_prog;
                end
            end
            default: begin
                n_res_status = pet_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_pcnt      <= '0;
            r_best_v    <= 1'b0;
            r_best_prog <= '0;
            r_best_pid  <= '0;
        end else if (i_cmd.commit) begin
            r_valid     <= n_valid;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_pcnt      <= n_pcnt;
            r_best_v    <= n_best_v;
            r_best_prog <= n_best_prog;
            r_best_pid  <= n_best_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_status <= n_res_status;
            r_res_found  <= n_res_found;
        end
    end

    // Output register: holds the result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {1'b0, pet_pkg::COUNT_W'(r_cnt), (r_pcnt != '0), r_best_v,
                           r_best_pid, r_best_prog, r_res_found, r_res_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[rtl/pat_entry_table.sv]
// Channel   Direction  Ports                          Beat
// s         in         i_s_tvalid o_s_tready i_s_tdata  one PAT entry, PMT arrival or lookup
// m         out        o_m_tvalid i_m_tready o_m_tdata  one result per input beat
//
// One item at a time. An item that searches the table (PAT entry with table id 0
// that is not a skipped NIT entry, PMT arrival, lookup) reads every slot in turn
// between acceptance and its result: the slot memory is read once per cycle by one port.
// Other items skip the scan. A stalled result stays in the output register, and the
// next item is taken only once it has been loaded. Reset is synchronous and empties
// the table at once; there is no clearing pass.
module pat_entry_table #(
    parameter int TABLE_DEPTH = pet_pkg::TABLE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // operation[1:0], table_id[9:2], pid[22:10], program_number[38:23],
    // entries_in_section[46:39], zero fill
    input  logic [pet_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // status[2:0], found_program[18:3], default_program[34:19], default_pid[47:35],
    // default_valid[48], any_pending[49], stored_count[54:50], zero fill
    output logic [pet_pkg::OUT_W-1:0] o_m_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready
);

    pet_pkg::t_dp_cmd w_cmd;
    pet_pkg::t_dp_sts w_sts;

    // Sequencer.
    pet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table, scan and result datapath.
    pet_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule

[rtl/pet_checker.sv]
module pet_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic [pet_pkg::IN_W-1:0]  i_s_tdata,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic [pet_pkg::OUT_W-1:0] o_m_tdata,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready
);

    // No result beat straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat shown after reset");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed");

    // One item at a time: no second beat is taken in the cycle after an accept.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an item is in work");

    // A stored entry always leaves a default program behind.
    a_stored_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] == pet_pkg::ST_STORED) |-> o_m_tdata[48])
        else $error("entry stored without a default program");

    // Without a default program its fields read as zero.
    a_default_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[48] |-> (o_m_tdata[47:19] == '0))
        else $error("default fields set without a default program");

endmodule

bind pat_entry_table pet_checker u_pet_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import pet_pkg::*;

    // Operation code that the block does not define; it must answer "not found".
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1600;
    localparam int POOL_SIZE    = 24;
    localparam int CYCLE_LIMIT  = 400000;

    // One input beat, field by field
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TID_W-1:0]  tid;
        logic [PID_W-1:0]  pid;
        logic [PROG_W-1:0] prog;
        logic [NSEC_W-1:0] nsec;
    } pat_item_t;

    // One result beat, field by field
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PROG_W-1:0]   found;
        logic [PROG_W-1:0]   dflt_prog;
        logic [PID_W-1:0]    dflt_pid;
        logic                dflt_valid;
        logic                any_pend;
        logic [COUNT_W-1:0]  used;
    } pat_report_t;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic [IN_W-1:0]    i_s_tdata  = '0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [OUT_W-1:0]   o_m_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;

    // Mirror of the table as the block should hold it
    logic               tbl_valid [TABLE_DEPTH];
    logic [PID_W-1:0]   tbl_pid   [TABLE_DEPTH];
    logic [PROG_W-1:0]  tbl_prog  [TABLE_DEPTH];
    logic               tbl_pend  [TABLE_DEPTH];
    logic               best_valid = 1'b0;
    logic [PROG_W-1:0]  best_prog  = '0;
    logic [PID_W-1:0]   best_pid   = '0;
    int                 tbl_used   = 0;

    pat_report_t        report_q [$];
    logic [PID_W-1:0]   pid_pool [POOL_SIZE];
    int                 status_seen [8];
    int                 errors        = 0;
    int                 items_sent    = 0;
    int                 beats_checked = 0;
    int                 cycle_count   = 0;
    logic               no_gaps       = 1'b0;

    pat_entry_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, report_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver stalls at random, about 30 percent of the time, except during the steady stretch.
    always @(negedge i_clk) begin
        i_m_tready <= no_gaps || ($urandom_range(0, 99) >= 30);
    end

    // Slot holding a PID, or -1 if no valid slot does.
    function automatic int slot_of(input logic [PID_W-1:0] pid);
        int hit;
        hit = -1;
        for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
            if (tbl_valid[s] && tbl_pid[s] == pid) hit = s;
        end
        return hit;
    endfunction

    // Applies one item to the mirrored table and returns the result it should give.
    function automatic pat_report_t update_pat_table(input pat_item_t it);
        pat_report_t r;
        int          slot;
        r.status   = ST_NOT_FOUND;
        r.found    = '0;
        r.any_pend = 1'b0;
        slot       = -1;
        case (it.op)
            OP_PAT: begin
                if (it.tid != '0) begin
                    r.status = ST_WRONG_TABLE;
                end else if (it.pid == NIT_PID && it.nsec >= NIT_KEEP_BELOW) begin
                    r.status = ST_NIT;
                end else begin
                    // Same PID overwrites its slot, otherwise the lowest free slot is taken.
                    slot = slot_of(it.pid);
                    if (slot < 0) begin
                        for (int s = 0; s < TABLE_DEPTH; s++) begin
                            if (slot < 0 && !tbl_valid[s]) slot = s;
                        end
                    end
                    if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        // A tie leaves the default where it is.
                        if (!best_valid || it.prog < best_prog) begin
                            best_valid = 1'b1;
                            best_prog  = it.prog;
                            best_pid   = it.pid;
                        end
                        tbl_valid[slot] = 1'b1;
                        tbl_pid[slot]   = it.pid;
                        tbl_prog[slot]  = it.prog;
                        tbl_pend[slot]  = 1'b1;
                        r.status        = ST_STORED;
                    end
                end
            end
            OP_PMT: begin
                slot = slot_of(it.pid);
                if (slot >= 0) begin
                    tbl_pend[slot] = 1'b0;
                    r.status       = ST_FOUND;
                end
            end
            OP_LOOKUP: begin
                slot = slot_of(it.pid);
                if (slot >= 0) begin
                    r.found  = tbl_prog[slot];
                    r.status = ST_FOUND;
                end
            end
            default: begin
            end
        endcase

        // Summary fields are taken after the update.
        tbl_used = 0;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (tbl_valid[s]) begin
                tbl_used++;
                if (tbl_pend[s]) r.any_pend = 1'b1;
            end
        end
        r.used       = tbl_used[COUNT_W-1:0];
        r.dflt_prog  = best_prog;
        r.dflt_pid   = best_pid;
        r.dflt_valid = best_valid;
        status_seen[r.status]++;
        return r;
    endfunction

    // Drives one beat, waits for it to be taken and records the result it should give.
    // Valid is left high so that a following beat can go out without a gap.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [TID_W-1:0] tid,
                             input logic [PID_W-1:0] pid, input logic [PROG_W-1:0] prog,
                             input logic [NSEC_W-1:0] nsec);
        pat_item_t it;
        it.op   = op;
        it.tid  = tid;
        it.pid  = pid;
        it.prog = prog;
        it.nsec = nsec;
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(0, 99) < 30) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tdata  <= {1'b0, nsec, prog, pid, tid, op};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        report_q.insert(report_q.size(), update_pat_table(it));
        items_sent++;
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Each result beat is compared with the oldest outstanding expectation.
    always @(posedge i_clk) begin : result_check
        pat_report_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            beats_checked++;
            if (report_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, data %h", $time, o_m_tdata);
            end else begin
                want = report_q.pop_front();
                check_field("status", 16'(want.status), 16'(o_m_tdata[2:0]));
                check_field("found_program", want.found, o_m_tdata[18:3]);
                check_field("default_program", want.dflt_prog, o_m_tdata[34:19]);
                check_field("default_pid", 16'(want.dflt_pid), 16'(o_m_tdata[47:35]));
                check_field("default_valid", 16'(want.dflt_valid), 16'(o_m_tdata[48]));
                check_field("any_pending", 16'(want.any_pend), 16'(o_m_tdata[49]));
                check_field("stored_count", 16'(want.used), 16'(o_m_tdata[54:50]));
            end
        end
    end

    // Empty table, every operation, NIT boundary, wrong table, default ties and overwrites.
    task automatic test_directed_cases();
        send_item(OP_LOOKUP, 8'h00, 13'd0, 16'd0, 8'd0);
        send_item(OP_PMT, 8'h00, 13'd5, 16'd0, 8'd0);
        send_item(OP_UNUSED, 8'hFF, 13'h1FFF, 16'hFFFF, 8'd253);
        send_item(OP_PAT, 8'hFF, 13'd100, 16'd0, 8'd1);
        send_item(OP_PAT, 8'h02, 13'd100, 16'd7, 8'd1);
        send_item(OP_PAT, 8'h00, NIT_PID, 16'd10, 8'd8);
        send_item(OP_PAT, 8'h00, NIT_PID, 16'd10, 8'd253);
        send_item(OP_PAT, 8'h00, NIT_PID, 16'd500, 8'd7);
        send_item(OP_PAT, 8'h00, 13'h1FFF, 16'hFFFF, 8'd0);
        send_item(OP_PAT, 8'h00, 13'd0, 16'd300, 8'd1);
        send_item(OP_PAT, 8'h00, 13'd1, 16'd300, 8'd2);
        send_item(OP_PAT, 8'h00, 13'd0, 16'd200, 8'd3);
        send_item(OP_LOOKUP, 8'h5A, 13'h1FFF, 16'h1234, 8'd99);
        send_item(OP_LOOKUP, 8'h00, 13'd1, 16'd0, 8'd0);
        send_item(OP_PMT, 8'h00, 13'h1FFF, 16'd0, 8'd0);
        send_item(OP_PMT, 8'h00, NIT_PID, 16'd0, 8'd0);
        send_item(OP_PMT, 8'h00, 13'd0, 16'd0, 8'd0);
        send_item(OP_PMT, 8'h00, 13'd1, 16'd0, 8'd0);
        send_item(OP_PMT, 8'h00, 13'd1, 16'd0, 8'd0);
        send_item(OP_LOOKUP, 8'h00, 13'd2, 16'd0, 8'd0);
        send_item(OP_PAT, 8'h00, 13'h1FFF, 16'd1, 8'd0);
        send_item(OP_UNUSED, 8'h00, 13'd0, 16'd0, 8'd0);
    endtask

    // Mostly well-formed traffic over a PID set that grows slowly, so the table
    // fills step by step; some fully random PIDs, wrong tables and unused codes.
    task automatic test_random_traffic();
        logic [OP_W-1:0]   op;
        logic [TID_W-1:0]  tid;
        logic [PID_W-1:0]  pid;
        logic [PROG_W-1:0] prog;
        logic [NSEC_W-1:0] nsec;
        int                span;
        int                pick;
        pid_pool[0] = NIT_PID;
        pid_pool[1] = '0;
        pid_pool[2] = '1;
        for (int i = 3; i < POOL_SIZE; i++) pid_pool[i] = PID_W'($urandom_range(0, 8191));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gaps = (n >= 600 && n < 900);
            span    = (3 + n / 40 > POOL_SIZE) ? POOL_SIZE : 3 + n / 40;
            pick    = $urandom_range(0, 99);
            op      = pick < 45 ? OP_PAT : pick < 65 ? OP_PMT : pick < 95 ? OP_LOOKUP
                                                                          : OP_UNUSED;
            if ($urandom_range(0, 9) == 0) pid = PID_W'($urandom_range(0, 8191));
            else                           pid = pid_pool[$urandom_range(0, span - 1)];
            if (op != OP_PAT)                    tid = TID_W'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) < 85) tid = '0;
            else                                 tid = TID_W'($urandom_range(1, 255));
            // Small section sizes often, to sit on both sides of the NIT threshold.
            if ($urandom_range(0, 2) == 0) nsec = NSEC_W'($urandom_range(0, 9));
            else                           nsec = NSEC_W'($urandom_range(0, 253));
            // Program zero is kept back so the full-table drop can show it is ignored.
            if (best_valid && $urandom_range(0, 9) == 0) prog = best_prog;
            else                                         prog = PROG_W'($urandom_range(1, 65535));
            send_item(op, tid, pid, prog, nsec);
        end
        no_gaps = 1'b0;
    endtask

    function automatic logic [PID_W-1:0] pick_fresh_pid();
        logic [PID_W-1:0] p;
        do p = PID_W'($urandom_range(0, 8191)); while (p == NIT_PID || slot_of(p) >= 0);
        return p;
    endfunction

    // Fill every slot, drop a new PID with the lowest program, then overwrite a slot and clear the pending flags.
    task automatic test_full_table();
        logic [PID_W-1:0] fresh;
        int               victim;
        while (tbl_used < TABLE_DEPTH) begin
            send_item(OP_PAT, '0, pick_fresh_pid(), PROG_W'($urandom_range(1, 65535)),
                      NSEC_W'($urandom_range(0, 253)));
        end
        fresh = pick_fresh_pid();
        send_item(OP_PAT, '0, fresh, '0, 8'd0);
        send_item(OP_LOOKUP, '0, fresh, '0, 8'd0);
        victim = $urandom_range(0, TABLE_DEPTH - 1);
        send_item(OP_PAT, '0, tbl_pid[victim], '0, 8'd5);
        send_item(OP_LOOKUP, '0, tbl_pid[victim], '0, 8'd0);
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            send_item(OP_PMT, TID_W'($urandom_range(0, 255)), tbl_pid[s],
                      PROG_W'($urandom_range(0, 65535)), NSEC_W'($urandom_range(0, 253)));
        end
    endtask

    initial begin
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            tbl_valid[s] = 1'b0;
            tbl_pend[s]  = 1'b0;
        end
        for (int i = 0; i < 8; i++) status_seen[i] = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_full_table();

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // Drain, then allow for any stray beat.
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (2 * TABLE_DEPTH + 20) @(posedge i_clk);

        $display("%0d beats sent, %0d results checked: %0d stored, %0d NIT skipped,",
                 items_sent, beats_checked, status_seen[ST_STORED], status_seen[ST_NIT]);
        $display("%0d wrong table, %0d table full, %0d hits, %0d misses.",
                 status_seen[ST_WRONG_TABLE], status_seen[ST_FULL], status_seen[ST_FOUND],
                 status_seen[ST_NOT_FOUND]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
